/* rtl/assert_macros.svh */
// Assertion macros shared by the battery monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define BMCC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define BMCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmcc_pkg.sv */
// Types, constants and helpers for the battery monitor and charge control unit.
package bmcc_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int SAMPLE_W   = 10;
    localparam int CURR_W     = 9;
    localparam int LEVEL_W    = 3;
    localparam int LANES      = 4;
    localparam int SUM_W      = 16;
    localparam int QUOT_W     = 10;
    localparam int GAIN_W     = 14;
    localparam int PROD_W     = 24;
    localparam int SCALE_W    = 29;
    localparam int RECIP_W    = 16;
    localparam int POST_SHIFT = 10;
    localparam int DIV10_SHIFT = 19;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // 0.1 V scale is 331*25/10240, 0.1 A scale is 331/1024
    localparam logic [GAIN_W-1:0]  VOLT_GAIN   = 14'd8275;
    localparam logic [GAIN_W-1:0]  CURR_GAIN   = 14'd331;
    // floor(y/10) == (y*52429)>>19 for y below 43690
    localparam logic [RECIP_W-1:0] DIV10_RECIP = 16'd52429;

    localparam logic [SAMPLE_W-1:0] LVL6_MIN = 10'd138;
    localparam logic [SAMPLE_W-1:0] LVL5_MIN = 10'd132;
    localparam logic [SAMPLE_W-1:0] LVL4_MIN = 10'd128;
    localparam logic [SAMPLE_W-1:0] LVL3_MIN = 10'd120;
    localparam logic [SAMPLE_W-1:0] LVL2_MIN = 10'd108;

    localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_5 = 3'd5;
    localparam logic [LEVEL_W-1:0] LEVEL_6 = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECISION_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEVEL      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LEVEL     = 2'd3;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST   = 16'd100;
    localparam logic [PERIOD_W-1:0] DECISION_PERIOD_RST = 16'd300;
    localparam logic [SAMPLE_W-1:0] STOP_LEVEL_RST      = 10'd140;
    localparam logic [SAMPLE_W-1:0] START_LEVEL_RST     = 10'd125;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_SERVICE = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] volt_one_sample;
        logic [SAMPLE_W-1:0] curr_one_sample;
        logic [SAMPLE_W-1:0] volt_two_sample;
        logic [SAMPLE_W-1:0] curr_two_sample;
    } in_item_t;

    typedef struct packed {
        logic                sampled;
        logic                ready_res;
        logic [SAMPLE_W-1:0] volt_one;
        logic [CURR_W-1:0]   curr_one;
        logic [SAMPLE_W-1:0] volt_two;
        logic [CURR_W-1:0]   curr_two;
        logic                charge_on;
        logic                full_mark;
        logic [LEVEL_W-1:0]  level;
    } out_item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_period;
        logic [PERIOD_W-1:0] decision_period;
        logic [SAMPLE_W-1:0] stop_level;
        logic [SAMPLE_W-1:0] start_level;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic tick;
        logic store;
        logic div_step;
        logic mul1;
        logic mul2;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic samp_zero;
        logic fill_now;
    } ctrl_status_t;

    function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] volt);
        logic [LEVEL_W-1:0] lvl;
        if (volt >= LVL6_MIN)
            lvl = LEVEL_6;
        else if (volt >= LVL5_MIN)
            lvl = LEVEL_5;
        else if (volt >= LVL4_MIN)
            lvl = LEVEL_4;
        else if (volt >= LVL3_MIN)
            lvl = LEVEL_3;
        else if (volt >= LVL2_MIN)
            lvl = LEVEL_2;
        else
            lvl = LEVEL_1;
        return lvl;
    endfunction

endpackage

/* rtl/bmcc_ctrl.sv */
// Sequencing controller: one item at a time through store, divide, scale, update.
`include "assert_macros.svh"

module bmcc_ctrl
    import bmcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_kind,
    input  logic         out_free,
    input  ctrl_status_t status,
    output logic         in_ready,
    output ctrl_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STORE = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       post_store;

    assign post_store = (state_reg == S_DIV) || (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_kind == KIND_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (status.samp_zero)
                        state_next = S_STORE;
                    else
                        state_next = S_DONE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = status.fill_now ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `BMCC_ASSERT_NEXT(a_tick_to_done, cmd.tick, state_reg == S_DONE, "tick item not at result")
    `BMCC_ASSERT_NEXT(a_store_once, cmd.store, post_store, "store state did not advance")

endmodule

/* rtl/bmcc_dp.sv */
// Datapath: countdowns, sample stores, running sums, divider, scaling, charge logic.
`include "assert_macros.svh"

module bmcc_dp
    import bmcc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    input  cfg_t         cfg,
    input  in_item_t     item,
    output ctrl_status_t status,
    output out_item_t    res
);

    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int WIN_SHIFT   = SUM_W + SLOT_W;
    localparam int WIN_RECIP_W = SUM_W + 1;
    localparam int QPROD_W     = SUM_W + WIN_RECIP_W;
    // floor(s/WINDOW) == (s*WIN_RECIP)>>WIN_SHIFT for every 16-bit s
    localparam logic [WIN_RECIP_W-1:0] WIN_RECIP =
        WIN_RECIP_W'(((longint'(1) << WIN_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));
    localparam logic [GAIN_W-1:0] LANE_GAIN [LANES] =
        '{VOLT_GAIN, CURR_GAIN, VOLT_GAIN, CURR_GAIN};

    logic [SAMPLE_W-1:0] smp_reg   [LANES];
    logic [SAMPLE_W-1:0] mem       [LANES][WINDOW];
    logic [SAMPLE_W-1:0] rd_reg    [LANES];
    logic [SUM_W-1:0]    sum_reg   [LANES];
    logic [SUM_W-1:0]    sum_next  [LANES];
    logic [QPROD_W-1:0]  qprod     [LANES];
    logic [QUOT_W-1:0]   quot_reg  [LANES];
    logic [PROD_W-1:0]   prod_reg  [LANES];
    logic [SCALE_W-1:0]  scale_reg [2];
    logic [SAMPLE_W-1:0] meas_reg  [LANES];

    logic [PERIOD_W-1:0]  samp_cnt_reg;
    logic [PERIOD_W-1:0]  dec_cnt_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 filled_reg;
    logic                 sampled_reg;
    logic                 charge_reg;
    logic                 full_reg;
    logic [LEVEL_W-1:0]   level_reg;

    logic                 slot_last;
    logic [SAMPLE_W-1:0]  volt_new;
    logic [SAMPLE_W-1:0]  lane_smp [LANES];

    assign lane_smp[0] = item.volt_one_sample;
    assign lane_smp[1] = item.curr_one_sample;
    assign lane_smp[2] = item.volt_two_sample;
    assign lane_smp[3] = item.curr_two_sample;

    assign slot_last = (slot_reg == SLOT_W'(WINDOW - 1));
    assign volt_new  = scale_reg[0][DIV10_SHIFT +: SAMPLE_W];

    assign status.samp_zero = (samp_cnt_reg == '0);
    assign status.fill_now  = filled_reg | slot_last;

    // entry being replaced is zero until the window has filled once
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            sum_next[i] = SUM_W'(({1'b0, sum_reg[i]}
                                  - {{(SUM_W - SAMPLE_W + 1){1'b0}},
                                     (filled_reg ? rd_reg[i] : SAMPLE_W'(0))})
                                  + {{(SUM_W - SAMPLE_W + 1){1'b0}}, smp_reg[i]});
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            qprod[i] = QPROD_W'(sum_reg[i]) * QPROD_W'(WIN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.accept)
            begin
                smp_reg[i] <= lane_smp[i];
                rd_reg[i]  <= mem[i][slot_reg];
            end
            if (cmd.store)
                mem[i][slot_reg] <= smp_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.div_step)
                quot_reg[i] <= qprod[i][WIN_SHIFT +: QUOT_W];
            if (cmd.mul1)
                prod_reg[i] <= PROD_W'(PROD_W'(quot_reg[i]) + PROD_W'(1))
                               * PROD_W'(LANE_GAIN[i]);
        end
        for (int j = 0; j < 2; j++)
        begin
            if (cmd.mul2)
                scale_reg[j] <= SCALE_W'(prod_reg[2*j][PROD_W-1:POST_SHIFT])
                                * SCALE_W'(DIV10_RECIP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_cnt_reg <= '0;
            dec_cnt_reg  <= '0;
            slot_reg     <= '0;
            filled_reg   <= 1'b0;
            sampled_reg  <= 1'b0;
            charge_reg   <= 1'b0;
            full_reg     <= 1'b0;
            level_reg    <= LEVEL_1;
            for (int i = 0; i < LANES; i++)
            begin
                sum_reg[i]  <= '0;
                meas_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
                sampled_reg <= 1'b0;
            if (cmd.tick)
            begin
                if (samp_cnt_reg != '0)
                    samp_cnt_reg <= samp_cnt_reg - PERIOD_W'(1);
                if (dec_cnt_reg != '0)
                    dec_cnt_reg <= dec_cnt_reg - PERIOD_W'(1);
            end
            if (cmd.store)
            begin
                samp_cnt_reg <= cfg.sample_period;
                sampled_reg  <= 1'b1;
                for (int i = 0; i < LANES; i++)
                    sum_reg[i] <= sum_next[i];
                if (slot_last)
                begin
                    slot_reg   <= '0;
                    filled_reg <= 1'b1;
                end
                else
                    slot_reg <= slot_reg + SLOT_W'(1);
            end
            if (cmd.update)
            begin
                meas_reg[0] <= volt_new;
                meas_reg[1] <= prod_reg[1][POST_SHIFT +: SAMPLE_W];
                meas_reg[2] <= scale_reg[1][DIV10_SHIFT +: SAMPLE_W];
                meas_reg[3] <= prod_reg[3][POST_SHIFT +: SAMPLE_W];
                level_reg   <= level_of(volt_new);
                if (dec_cnt_reg == '0)
                begin
                    dec_cnt_reg <= cfg.decision_period;
                    // stop test wins when the thresholds overlap
                    if (volt_new >= cfg.stop_level)
                    begin
                        full_reg   <= 1'b1;
                        charge_reg <= 1'b0;
                    end
                    else if (volt_new <= cfg.start_level)
                    begin
                        full_reg   <= 1'b0;
                        charge_reg <= 1'b1;
                    end
                    else
                        charge_reg <= !full_reg;
                end
            end
        end
    end

    assign res.sampled   = sampled_reg;
    assign res.ready_res = filled_reg;
    assign res.volt_one  = meas_reg[0];
    assign res.curr_one  = meas_reg[1][CURR_W-1:0];
    assign res.volt_two  = meas_reg[2];
    assign res.curr_two  = meas_reg[3][CURR_W-1:0];
    assign res.charge_on = charge_reg;
    assign res.full_mark = full_reg;
    assign res.level     = level_reg;

    `BMCC_ASSERT_NEXT(a_filled_sticky, filled_reg, filled_reg, "filled flag dropped")
    `BMCC_ASSERT(a_level_range, level_reg >= LEVEL_1 && level_reg <= LEVEL_6, "level out of range")
    `BMCC_ASSERT(a_charge_full_excl, !(charge_reg && full_reg), "charging while marked full")

endmodule

/* rtl/battery_monitor_charge_control_unit.sv */
// Top level of the battery monitor: config registers, controller, datapath, result register.
// Result after accept: a tick item, or a service item with the sample countdown running, goes
// straight to the result load; a sampling service item before the windows fill goes through store
// first; once filled: store, reciprocal window divide, two scale multiplies, update, result load.
// One item in flight; the next is accepted the cycle after the result register loads.
// Reset (async, active low) clears control state and loads register defaults; store RAM is not cleared.

module battery_monitor_charge_control_unit
    import bmcc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  in_item_t              sample_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t         cfg_reg;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    out_item_t    res;
    out_item_t    result_item_reg;
    logic         result_valid_reg;
    logic         out_free;

    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_period   <= SAMPLE_PERIOD_RST;
            cfg_reg.decision_period <= DECISION_PERIOD_RST;
            cfg_reg.stop_level      <= STOP_LEVEL_RST;
            cfg_reg.start_level     <= START_LEVEL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD:   cfg_reg.sample_period   <= cfg_data[PERIOD_W-1:0];
                CFG_DECISION_PERIOD: cfg_reg.decision_period <= cfg_data[PERIOD_W-1:0];
                CFG_STOP_LEVEL:      cfg_reg.stop_level      <= cfg_data[SAMPLE_W-1:0];
                CFG_START_LEVEL:     cfg_reg.start_level     <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.load_out)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            result_item_reg <= res;
    end

    bmcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_valid),
        .in_kind  (sample_item.kind),
        .out_free (out_free),
        .status   (status),
        .in_ready (sample_ready),
        .cmd      (cmd)
    );

    bmcc_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .item   (sample_item),
        .status (status),
        .res    (res)
    );

endmodule

/* dv/tb_battery_monitor_charge_control_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the battery monitor and charge control unit.
module tb_battery_monitor_charge_control_unit;
    import bmcc_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int IDLE_PCT     = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    in_item_t              sample_item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_item_t    pending_q[$];
    out_item_t   readout_q[$];
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    bit          steady = 1'b0;
    int          center = 150;

    // monitor model state
    logic [PERIOD_W-1:0] sample_period_r   = SAMPLE_PERIOD_RST;
    logic [PERIOD_W-1:0] decision_period_r = DECISION_PERIOD_RST;
    logic [SAMPLE_W-1:0] stop_level_r      = STOP_LEVEL_RST;
    logic [SAMPLE_W-1:0] start_level_r     = START_LEVEL_RST;
    logic [SAMPLE_W-1:0] window_mem [LANES][WIN] = '{default: '0};
    int unsigned         slot = 0;
    bit                  filled_r = 1'b0;
    logic [PERIOD_W-1:0] sample_cd = '0;
    logic [PERIOD_W-1:0] decision_cd = '0;
    logic [SAMPLE_W-1:0] volt_one_r = '0;
    logic [SAMPLE_W-1:0] volt_two_r = '0;
    logic [CURR_W-1:0]   curr_one_r = '0;
    logic [CURR_W-1:0]   curr_two_r = '0;
    bit                  charge_r = 1'b0;
    bit                  full_r = 1'b0;
    logic [LEVEL_W-1:0]  level_r = LEVEL_1;

    battery_monitor_charge_control_unit #(
        .WINDOW(WIN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned lane_mean(input int lane);
        int unsigned total;
        total = 0;
        for (int k = 0; k < WIN; k++)
        begin
            total += window_mem[lane][k];
        end
        return (total & 32'hFFFF) / WIN;
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_volt(input int unsigned avg);
        int unsigned scaled;
        scaled = ((avg + 1) * 331 * 25) / 10240;
        return scaled[SAMPLE_W-1:0];
    endfunction

    function automatic logic [CURR_W-1:0] to_curr(input int unsigned avg);
        int unsigned scaled;
        scaled = ((avg + 1) * 331) / 1024;
        return scaled[CURR_W-1:0];
    endfunction

    task automatic update_readout(input in_item_t it);
        out_item_t r;
        bit        stored;
        stored = 1'b0;
        if (it.kind == KIND_TICK)
        begin
            if (sample_cd != 0)
                sample_cd--;
            if (decision_cd != 0)
                decision_cd--;
        end
        else if (sample_cd == 0)
        begin
            sample_cd = sample_period_r;
            stored = 1'b1;
            window_mem[0][slot] = it.volt_one_sample;
            window_mem[1][slot] = it.curr_one_sample;
            window_mem[2][slot] = it.volt_two_sample;
            window_mem[3][slot] = it.curr_two_sample;
            slot++;
            if (slot >= WIN)
            begin
                slot = 0;
                filled_r = 1'b1;
            end
            if (filled_r)
            begin
                volt_one_r = to_volt(lane_mean(0));
                curr_one_r = to_curr(lane_mean(1));
                volt_two_r = to_volt(lane_mean(2));
                curr_two_r = to_curr(lane_mean(3));
                if (decision_cd == 0)
                begin
                    decision_cd = decision_period_r;
                    // stop test wins when the levels overlap
                    if (volt_one_r >= stop_level_r)
                    begin
                        full_r = 1'b1;
                        charge_r = 1'b0;
                    end
                    else if (volt_one_r <= start_level_r)
                    begin
                        full_r = 1'b0;
                        charge_r = 1'b1;
                    end
                    else
                    begin
                        charge_r = !full_r;
                    end
                end
                if (volt_one_r >= LVL6_MIN)
                    level_r = LEVEL_6;
                else if (volt_one_r >= LVL5_MIN)
                    level_r = LEVEL_5;
                else if (volt_one_r >= LVL4_MIN)
                    level_r = LEVEL_4;
                else if (volt_one_r >= LVL3_MIN)
                    level_r = LEVEL_3;
                else if (volt_one_r >= LVL2_MIN)
                    level_r = LEVEL_2;
                else
                    level_r = LEVEL_1;
            end
        end
        r.sampled   = stored;
        r.ready_res = filled_r;
        r.volt_one  = volt_one_r;
        r.curr_one  = curr_one_r;
        r.volt_two  = volt_two_r;
        r.curr_two  = curr_two_r;
        r.charge_on = charge_r;
        r.full_mark = full_r;
        r.level     = level_r;
        readout_q.push_back(r);
    endtask

    task automatic compare_field(input string fname, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic check_readout(input out_item_t act);
        out_item_t exp_r;
        if (readout_q.size() == 0)
        begin
            $display("%0t: unexpected result expected none actual %h", $time, act);
            mismatch_count++;
        end
        else
        begin
            exp_r = readout_q.pop_front();
            compare_field("sampled", 16'(exp_r.sampled), 16'(act.sampled));
            compare_field("ready_res", 16'(exp_r.ready_res), 16'(act.ready_res));
            compare_field("volt_one", 16'(exp_r.volt_one), 16'(act.volt_one));
            compare_field("curr_one", 16'(exp_r.curr_one), 16'(act.curr_one));
            compare_field("volt_two", 16'(exp_r.volt_two), 16'(act.volt_two));
            compare_field("curr_two", 16'(exp_r.curr_two), 16'(act.curr_two));
            compare_field("charge_on", 16'(exp_r.charge_on), 16'(act.charge_on));
            compare_field("full_mark", 16'(exp_r.full_mark), 16'(act.full_mark));
            compare_field("level", 16'(exp_r.level), 16'(act.level));
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_item  <= '0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                update_readout(sample_item);
            if (!sample_valid || sample_ready)
            begin
                if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    sample_valid <= 1'b1;
                    sample_item  <= pending_q.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_readout(result_item);
            result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic in_item_t make_item(input logic kind, input int unsigned v1,
                                           input int unsigned c1, input int unsigned v2,
                                           input int unsigned c2);
        in_item_t it;
        it.kind            = kind;
        it.volt_one_sample = v1[SAMPLE_W-1:0];
        it.curr_one_sample = c1[SAMPLE_W-1:0];
        it.volt_two_sample = v2[SAMPLE_W-1:0];
        it.curr_two_sample = c2[SAMPLE_W-1:0];
        return it;
    endfunction

    function automatic in_item_t random_item(input logic kind);
        return make_item(kind, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom_range(0, 1023));
    endfunction

    function automatic int unsigned near_center();
        int v;
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 1023);
        v = center + int'($urandom_range(0, 30)) - 15;
        return v;
    endfunction

    function automatic in_item_t service_item();
        in_item_t it;
        center = center + int'($urandom_range(0, 6)) - 3;
        if (center < 110)
            center = 110;
        if (center > 200)
            center = 200;
        it = make_item(KIND_SERVICE, near_center(), $urandom_range(0, 1023),
                       near_center(), $urandom_range(0, 1023));
        return it;
    endfunction

    // mostly tick runs, sized for short sample periods to let the countdown expire, then a service item
    task automatic queue_phase(input int n, input int unsigned sp);
        int count;
        int ticks;
        count = 0;
        while (count < n)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if (sp > 4)
                    ticks = $urandom_range(0, 3);
                else
                    ticks = sp + (($urandom_range(0, 3) == 0) ? 1 : 0);
                if (ticks > 0 && $urandom_range(0, 9) == 0)
                    ticks--;
                repeat (ticks) pending_q.push_back(random_item(KIND_TICK));
                pending_q.push_back(service_item());
                count += ticks + 1;
            end
            else
            begin
                pending_q.push_back(random_item(logic'($urandom_range(0, 1))));
                count++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SAMPLE_PERIOD:   sample_period_r = data;
            CFG_DECISION_PERIOD: decision_period_r = data;
            CFG_STOP_LEVEL:      stop_level_r = data[SAMPLE_W-1:0];
            CFG_START_LEVEL:     start_level_r = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int unsigned sp, input int unsigned dp,
                              input int unsigned stop, input int unsigned start);
        write_reg(CFG_SAMPLE_PERIOD, sp[CFG_DATA_W-1:0]);
        write_reg(CFG_DECISION_PERIOD, dp[CFG_DATA_W-1:0]);
        write_reg(CFG_STOP_LEVEL, stop[CFG_DATA_W-1:0]);
        write_reg(CFG_START_LEVEL, start[CFG_DATA_W-1:0]);
    endtask

    // sender holds until every result is back
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_q.size() != 0 || sample_valid || readout_q.size() != 0);
    endtask

    initial
    begin
        int unsigned sp;
        int unsigned dp;
        int unsigned stop;
        int unsigned start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults after reset
        pending_q.push_back(make_item(KIND_SERVICE, 1023, 0, 1023, 0));
        pending_q.push_back(make_item(KIND_SERVICE, 0, 1023, 0, 1023));
        pending_q.push_back(make_item(KIND_TICK, 1023, 1023, 1023, 1023));
        wait_idle();

        // zero periods, decision between widest levels
        set_config(0, 0, 827, 0);
        for (int i = 0; i < 16; i++)
        begin
            if (i >= 12)
                pending_q.push_back(make_item(KIND_SERVICE, 150, 150, 150, 150));
            else if (i % 2 == 0)
                pending_q.push_back(make_item(KIND_SERVICE, 1023, 1023, 1023, 1023));
            else
                pending_q.push_back(make_item(KIND_SERVICE, 0, 0, 0, 0));
        end
        pending_q.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        wait_idle();

        // service while countdown is running, stop level at zero
        set_config(2, 0, 0, 827);
        pending_q.push_back(make_item(KIND_SERVICE, 140, 200, 140, 200));
        pending_q.push_back(make_item(KIND_SERVICE, 1023, 1023, 1023, 1023));
        pending_q.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        pending_q.push_back(make_item(KIND_TICK, 0, 0, 0, 0));
        pending_q.push_back(make_item(KIND_SERVICE, 160, 50, 160, 50));
        wait_idle();

        for (int ph = 0; ph < 9; ph++)
        begin
            sp = (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 4);
            dp = (ph % 3 == 0) ? 0 : $urandom_range(1, 12);
            case (ph)
                4:
                begin
                    start = $urandom_range(125, 150);
                    stop  = start - $urandom_range(0, 10);
                end
                5:
                begin
                    stop  = 0;
                    start = 827;
                end
                7:
                begin
                    stop  = $urandom_range(0, 827);
                    start = $urandom_range(0, 827);
                end
                default:
                begin
                    stop  = $urandom_range(125, 150);
                    start = stop - $urandom_range(0, 20);
                end
            endcase
            steady = (ph == 2);
            set_config(sp, dp, stop, start);
            queue_phase(200, sp);
            wait_idle();
        end
        steady = 1'b0;

        // longest periods last, since they stall further sampling
        set_config(16'hFFFF, 16'hFFFF, STOP_LEVEL_RST, START_LEVEL_RST);
        queue_phase(100, 16'hFFFF);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (readout_q.size() != 0)
        begin
            $display("%0t: results missing expected %0d actual 0", $time, readout_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
